/* hdl/drnm_pkg.sv */
`timescale 1ns / 1ps

package drnm_pkg;

  localparam int unsigned MAX_ENTRIES = 64;
  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam int unsigned ETA_W  = 12;
  localparam int unsigned PHI_W  = 11;
  localparam int unsigned DIST_W = 25;
  localparam int unsigned SQE_W  = 2 * ETA_W;
  localparam int unsigned SQP_W  = 2 * PHI_W - 1;

  localparam logic [DIST_W-1:0] DIST_ALL_ONES  = '1;
  localparam logic [DIST_W-1:0] RADIUS_SQ_RST  = DIST_W'(16900);
  localparam logic [PHI_W-1:0]  PHI_HALF       = PHI_W'(1024);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } drnm_op_e;

  typedef struct packed {
    logic             load;       // capture query coordinates, reset minimum
    logic             we;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             respond;
    logic             is_query;
    logic             dropped;
  } drnm_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } drnm_sts_t;

endpackage

/* hdl/drnm_ctrl.sv */
`timescale 1ns / 1ps

module drnm_ctrl import drnm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] operation_i,
  output logic       busy_o,
  input  drnm_sts_t  sts_i,
  output drnm_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESP
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] idx_q;
  logic             query_q;
  logic             drop_q;

  logic accept;
  logic full;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;
  assign full   = (count_q == CNT_W'(MAX_ENTRIES));

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = accept;
    cmd_o.we       = accept && (operation_i == OP_APPEND) && !full;
    cmd_o.wr_addr  = count_q[IDX_W-1:0];
    cmd_o.rd_en    = (state_q == ST_SCAN) && (idx_q != count_q);
    cmd_o.rd_addr  = idx_q[IDX_W-1:0];
    cmd_o.respond  = (state_q == ST_RESP);
    cmd_o.is_query = query_q;
    cmd_o.dropped  = drop_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      query_q <= 1'b0;
      drop_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            query_q <= 1'b0;
            drop_q  <= 1'b0;
            idx_q   <= '0;
            state_q <= ST_RESP;
            case (operation_i)
              OP_CLEAR: begin
                count_q <= '0;
              end
              OP_APPEND: begin
                if (full) begin
                  drop_q <= 1'b1;
                end else begin
                  count_q <= count_q + CNT_W'(1);
                end
              end
              OP_QUERY: begin
                query_q <= 1'b1;
                state_q <= ST_SCAN;
              end
              default: begin
                // unused code: entry count unchanged, default result
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (idx_q == count_q) begin
            state_q <= ST_DRAIN;
          end else begin
            idx_q <= idx_q + CNT_W'(1);
          end
        end
        ST_DRAIN: begin
          if (!sts_i.pipe_busy) begin
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/drnm_dpath.sv */
`timescale 1ns / 1ps

module drnm_dpath import drnm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ETA_W-1:0]  eta_i,
  input  logic [PHI_W-1:0]  phi_i,
  input  logic [DIST_W-1:0] radius_sq_i,
  input  drnm_cmd_t         cmd_i,
  output drnm_sts_t         sts_o,
  output logic              done_o,
  output logic              matched_o,
  output logic [DIST_W-1:0] min_dist_sq_o,
  output logic              dropped_o
);

  logic [ETA_W-1:0] eta_mem [MAX_ENTRIES];
  logic [PHI_W-1:0] phi_mem [MAX_ENTRIES];

  logic [ETA_W-1:0]  q_eta_q;
  logic [PHI_W-1:0]  q_phi_q;
  logic [ETA_W-1:0]  r_eta_q;
  logic [PHI_W-1:0]  r_phi_q;
  logic [ETA_W-1:0]  ade_q;
  logic [PHI_W-1:0]  adp_q;
  logic [SQE_W-1:0]  sqe_q;
  logic [SQP_W-1:0]  sqp_q;
  logic [DIST_W-1:0] min_q;
  logic              v0_q, v1_q, v2_q;
  logic              done_q, matched_q, dropped_q;
  logic [DIST_W-1:0] dist_q;

  logic signed [ETA_W:0] deta;
  logic [ETA_W:0]        deta_abs;
  logic [PHI_W-1:0]      dphi;
  logic [PHI_W-1:0]      dphi_fold;
  logic [DIST_W-1:0]     sum;

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      eta_mem[cmd_i.wr_addr] <= eta_i;
      phi_mem[cmd_i.wr_addr] <= phi_i;
    end
    if (cmd_i.rd_en) begin
      r_eta_q <= eta_mem[cmd_i.rd_addr];
      r_phi_q <= phi_mem[cmd_i.rd_addr];
    end
  end

  // eta difference magnitude; phi difference taken mod 2pi, folded to at most pi
  always_comb begin
    deta      = $signed({r_eta_q[ETA_W-1], r_eta_q}) - $signed({q_eta_q[ETA_W-1], q_eta_q});
    deta_abs  = deta[ETA_W] ? (ETA_W+1)'(-deta) : deta;
    dphi      = r_phi_q - q_phi_q;
    dphi_fold = (dphi > PHI_HALF) ? PHI_W'(-dphi) : dphi;
    sum       = DIST_W'(sqe_q) + DIST_W'(sqp_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      q_eta_q <= eta_i;
      q_phi_q <= phi_i;
    end
    if (v0_q) begin
      ade_q <= deta_abs[ETA_W-1:0];
      adp_q <= dphi_fold;
    end
    if (v1_q) begin
      sqe_q <= SQE_W'(ade_q) * SQE_W'(ade_q);
      sqp_q <= SQP_W'(adp_q) * SQP_W'(adp_q);
    end
    if (cmd_i.load) begin
      min_q <= DIST_ALL_ONES;
    end else if (v2_q && (sum < min_q)) begin
      min_q <= sum;
    end
    if (cmd_i.respond) begin
      matched_q <= cmd_i.is_query && (min_q < radius_sq_i);
      dist_q    <= cmd_i.is_query ? min_q : DIST_ALL_ONES;
      dropped_q <= cmd_i.dropped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v0_q   <= cmd_i.rd_en;
      v1_q   <= v0_q;
      v2_q   <= v1_q;
      done_q <= cmd_i.respond;
    end
  end

  assign sts_o.pipe_busy = v0_q || v1_q || v2_q;
  assign done_o          = done_q;
  assign matched_o       = matched_q;
  assign min_dist_sq_o   = dist_q;
  assign dropped_o       = dropped_q;

endmodule

/* hdl/delta_r_nearest_match_unit.sv */
`timescale 1ns / 1ps

// Nearest match in eta/phi. Start an item while busy_o is low. Every item gives
// exactly one result, shown for a single cycle with done_o high; the receiver
// cannot stall it, so it must take the result in that cycle. Clear, append and
// unused codes pass from accept through the response state back to idle, and
// the result shows as busy_o falls. A query scans every stored entry, then
// waits for the pipeline to drain before the response state: the scan reads
// the entry memory once per cycle through one read port, followed by a
// 3-stage distance/square/minimum pipeline.
module delta_r_nearest_match_unit import drnm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        operation_i,
  input  logic [ETA_W-1:0]  eta_i,
  input  logic [PHI_W-1:0]  phi_i,
  output logic              done_o,
  output logic              matched_o,
  output logic [DIST_W-1:0] min_dist_sq_o,
  output logic              dropped_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  drnm_cmd_t cmd;
  drnm_sts_t sts;

  logic [DIST_W-1:0] radius_sq_q;
  logic              reg_sel;

  assign reg_sel = (paddr[2] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? 32'(radius_sq_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_sq_q <= RADIUS_SQ_RST;
    end else if (psel && penable && pwrite && reg_sel) begin
      radius_sq_q <= pwdata[DIST_W-1:0];
    end
  end

  drnm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .busy_o      (busy_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  drnm_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .eta_i         (eta_i),
    .phi_i         (phi_i),
    .radius_sq_i   (radius_sq_q),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .done_o        (done_o),
    .matched_o     (matched_o),
    .min_dist_sq_o (min_dist_sq_o),
    .dropped_o     (dropped_o)
  );

endmodule

/* tb/delta_r_nearest_match_checker.sv */
`timescale 1ns / 1ps

// Watches the item, result and register channels of the nearest-match unit,
// keeps its own copy of the entry table and radius, and compares every result
// with the oldest outstanding prediction.
module delta_r_nearest_match_checker import drnm_pkg::*; #(
  parameter logic [2:0] RADIUS_ADDR = 3'd0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [1:0]        operation_i,
  input  logic [ETA_W-1:0]  eta_i,
  input  logic [PHI_W-1:0]  phi_i,
  input  logic              done_i,
  input  logic              matched_i,
  input  logic [DIST_W-1:0] min_dist_sq_i,
  input  logic              dropped_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  input  logic              pready,
  output int unsigned       error_count_o,
  output int unsigned       outstanding_o,
  output int unsigned       queries_o,
  output int unsigned       matches_o,
  output int unsigned       drops_o
);

  localparam int PHI_TURN = 2048;  // 2*pi in LSB
  localparam int PHI_PI   = 1024;

  typedef struct packed {
    logic              matched;
    logic [DIST_W-1:0] dist_sq;
    logic              dropped;
  } match_result_t;

  logic signed [ETA_W-1:0] table_eta [MAX_ENTRIES];
  logic signed [PHI_W-1:0] table_phi [MAX_ENTRIES];
  int unsigned             table_fill;
  logic [DIST_W-1:0]       radius_sq;
  match_result_t           results_due [$];

  function automatic int unsigned delta_r_sq(logic signed [ETA_W-1:0] ea,
                                             logic signed [PHI_W-1:0] pa,
                                             logic signed [ETA_W-1:0] eb,
                                             logic signed [PHI_W-1:0] pb);
    int de;
    int dp;
    de = int'(ea) - int'(eb);
    if (de < 0) de = -de;
    // phi difference mod 2*pi, folded so it never exceeds pi
    dp = (int'(pa) - int'(pb)) & (PHI_TURN - 1);
    if (dp > PHI_PI) dp = PHI_TURN - dp;
    return de * de + dp * dp;
  endfunction

  task automatic predict_item(input logic [1:0] op,
                              input logic signed [ETA_W-1:0] eta,
                              input logic signed [PHI_W-1:0] phi);
    match_result_t res;
    int unsigned d;
    res = '{matched: 1'b0, dist_sq: DIST_ALL_ONES, dropped: 1'b0};
    case (op)
      OP_CLEAR: table_fill = 0;
      OP_APPEND: begin
        if (table_fill >= MAX_ENTRIES) begin
          res.dropped = 1'b1;
        end else begin
          table_eta[table_fill] = eta;
          table_phi[table_fill] = phi;
          table_fill++;
        end
      end
      OP_QUERY: begin
        queries_o++;
        for (int i = 0; i < table_fill; i++) begin
          d = delta_r_sq(table_eta[i], table_phi[i], eta, phi);
          if (d < res.dist_sq) res.dist_sq = DIST_W'(d);
        end
        res.matched = (res.dist_sq < radius_sq);
      end
      default: ;  // unused code: no state change
    endcase
    results_due.push_back(res);
  endtask

  task automatic check_result();
    match_result_t want;
    if (results_due.size() == 0) begin
      $error("result with no item outstanding");
      error_count_o++;
    end else begin
      want = results_due.pop_front();
      if (matched_i !== want.matched) begin
        $error("matched: expected %0d, got %0d", want.matched, matched_i);
        error_count_o++;
      end
      if (min_dist_sq_i !== want.dist_sq) begin
        $error("min_dist_sq: expected %0d, got %0d", want.dist_sq, min_dist_sq_i);
        error_count_o++;
      end
      if (dropped_i !== want.dropped) begin
        $error("dropped: expected %0d, got %0d", want.dropped, dropped_i);
        error_count_o++;
      end
      if (want.matched) matches_o++;
      if (want.dropped) drops_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_fill    = 0;
      radius_sq     = RADIUS_SQ_RST;
      results_due.delete();
      error_count_o = 0;
      outstanding_o = 0;
      queries_o     = 0;
      matches_o     = 0;
      drops_o       = 0;
    end else begin
      if (start_i && !busy_i) predict_item(operation_i, eta_i, phi_i);
      if (done_i) check_result();
      if (psel && penable && pready && paddr == RADIUS_ADDR) begin
        if (pwrite) begin
          radius_sq = pwdata[DIST_W-1:0];
        end else if (prdata[DIST_W-1:0] !== radius_sq) begin
          $error("match_radius_sq: expected %0d, got %0d", radius_sq,
                 prdata[DIST_W-1:0]);
          error_count_o++;
        end
      end
      outstanding_o = results_due.size();
    end
  end

endmodule

/* tb/delta_r_nearest_match_unit_test.sv */
`timescale 1ns / 1ps

module delta_r_nearest_match_unit_test;
  import drnm_pkg::*;

  localparam logic [2:0] RADIUS_ADDR  = 3'd0;
  localparam logic [1:0] OP_RESERVED  = 2'd3;
  localparam int unsigned RADIUS_MAX  = 17817601;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned DRAIN       = 80;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [1:0]        operation_i;
  logic [ETA_W-1:0]  eta_i;
  logic [PHI_W-1:0]  phi_i;
  logic              done_o;
  logic              matched_o;
  logic [DIST_W-1:0] min_dist_sq_o;
  logic              dropped_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int unsigned error_count;
  int unsigned outstanding;
  int unsigned query_count;
  int unsigned match_count;
  int unsigned drop_count;

  int unsigned cycle_count;
  int unsigned items_done;
  int unsigned radius_writes;
  bit          calm;
  int          placed_eta [$];  // entries appended since the last clear
  int          placed_phi [$];

  delta_r_nearest_match_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .operation_i   (operation_i),
    .eta_i         (eta_i),
    .phi_i         (phi_i),
    .done_o        (done_o),
    .matched_o     (matched_o),
    .min_dist_sq_o (min_dist_sq_o),
    .dropped_o     (dropped_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  delta_r_nearest_match_checker #(
    .RADIUS_ADDR (RADIUS_ADDR)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .operation_i   (operation_i),
    .eta_i         (eta_i),
    .phi_i         (phi_i),
    .done_i        (done_o),
    .matched_i     (matched_o),
    .min_dist_sq_i (min_dist_sq_o),
    .dropped_i     (dropped_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .error_count_o (error_count),
    .outstanding_o (outstanding),
    .queries_o     (query_count),
    .matches_o     (match_count),
    .drops_o       (drop_count)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  task automatic send_item(input logic [1:0] op, input int eta, input int phi);
    @(negedge clk_i);
    start_i     = 1'b1;
    operation_i = op;
    eta_i       = ETA_W'(eta);
    phi_i       = PHI_W'(phi);
    do @(posedge clk_i); while (busy_o);
    case (op)
      OP_CLEAR: begin
        placed_eta.delete();
        placed_phi.delete();
      end
      OP_APPEND: begin
        if (placed_eta.size() < MAX_ENTRIES) begin
          placed_eta.push_back(int'($signed(ETA_W'(eta))));
          placed_phi.push_back(int'($signed(PHI_W'(phi))));
        end
      end
      default: ;
    endcase
    if (op != OP_RESERVED) items_done++;
  endtask

  // drop start and put junk on the fields while idle
  task automatic idle(input int unsigned n);
    if (n != 0) begin
      @(negedge clk_i);
      start_i     = 1'b0;
      operation_i = 2'($urandom);
      eta_i       = ETA_W'($urandom);
      phi_i       = PHI_W'($urandom);
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_and_idle(input logic [1:0] op, input int eta, input int phi);
    send_item(op, eta, phi);
    idle(rand_gap());
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start_i = 1'b0;
    while (outstanding != 0 || busy_o) @(negedge clk_i);
  endtask

  task automatic reg_access(input logic wr, input logic [31:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = RADIUS_ADDR;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic query_near();
    int k;
    int de;
    int dp;
    if (placed_eta.size() == 0 || $urandom_range(0, 2) == 0) begin
      send_and_idle(OP_QUERY, $urandom, $urandom);
    end else begin
      k = $urandom_range(0, placed_eta.size() - 1);
      de = 0;
      dp = 0;
      if ($urandom_range(0, 9) > 1) begin
        de = $urandom_range(0, 300) - 150;
        dp = $urandom_range(0, 300) - 150;
      end
      send_and_idle(OP_QUERY, placed_eta[k] + de, placed_phi[k] + dp);
    end
  endtask

  // one random sequence: mostly table loads followed by queries, some noise
  task automatic run_burst();
    int unsigned r;
    int unsigned n;
    calm = ($urandom_range(0, 99) < 15);
    if ($urandom_range(0, 99) < 20) begin
      repeat ($urandom_range(1, 6)) send_and_idle(2'($urandom), $urandom, $urandom);
    end else begin
      if ($urandom_range(0, 9) < 7) send_and_idle(OP_CLEAR, $urandom, $urandom);
      r = $urandom_range(0, 99);
      if (r < 60) n = $urandom_range(1, 8);
      else if (r < 85) n = $urandom_range(9, 40);
      else n = $urandom_range(58, 70);
      repeat (n) send_and_idle(OP_APPEND, $urandom, $urandom);
      repeat ($urandom_range(1, 6)) query_near();
    end
    calm = 1'b0;
  endtask

  initial begin
    int unsigned radius_set [6];
    int unsigned phase_start;

    rst_ni      = 1'b0;
    start_i     = 1'b0;
    operation_i = OP_CLEAR;
    eta_i       = '0;
    phi_i       = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = RADIUS_ADDR;
    pwdata      = '0;
    calm        = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part, default radius 130^2
    send_and_idle(OP_QUERY, 0, 0);             // empty table
    send_and_idle(OP_RESERVED, 5, 5);
    send_and_idle(OP_APPEND, -2048, -1024);
    send_and_idle(OP_APPEND, 2047, 1023);
    send_and_idle(OP_APPEND, 0, 0);
    send_and_idle(OP_QUERY, 2047, 1023);       // exact hit
    send_and_idle(OP_QUERY, -2048, 1023);      // phi wraps across pi
    send_and_idle(OP_QUERY, 130, 0);           // distance equals radius
    send_and_idle(OP_QUERY, 129, 0);           // just inside
    send_and_idle(OP_QUERY, 0, -1024);         // phi difference of exactly pi
    send_and_idle(OP_RESERVED, 0, 0);
    send_and_idle(OP_QUERY, -2048, -1024);
    send_and_idle(OP_CLEAR, 0, 0);
    send_and_idle(OP_QUERY, -2048, -1024);     // empty after clear
    send_and_idle(OP_APPEND, -2048, -1024);
    send_and_idle(OP_QUERY, 2047, 0);          // largest distance
    send_and_idle(OP_CLEAR, 0, 0);
    send_and_idle(OP_APPEND, 'h555, 'h2AA);
    send_and_idle(OP_QUERY, 'hAAA, 'h555);
    send_and_idle(OP_APPEND, 'hAAA, 'h555);
    send_and_idle(OP_QUERY, 'h555, 'h2AA);
    send_and_idle(OP_CLEAR, 0, 0);

    radius_set[0] = 0;
    radius_set[1] = RADIUS_MAX;
    radius_set[2] = 1;
    radius_set[3] = 16900;
    radius_set[4] = $urandom_range(0, RADIUS_MAX);
    radius_set[5] = $urandom_range(0, 40000);
    foreach (radius_set[p]) begin
      wait_idle();
      reg_access(1'b1, radius_set[p]);
      reg_access(1'b0, '0);
      radius_writes++;
      phase_start = items_done;
      while (items_done - phase_start < PHASE_ITEMS) run_burst();
    end

    wait_idle();
    repeat (DRAIN) @(posedge clk_i);

    $display("Ran %0d items over %0d radius settings: %0d queries, %0d matched,",
             items_done, radius_writes, query_count, match_count);
    $display("%0d appends refused on a full table, %0d cycles.", drop_count, cycle_count);
    if (error_count == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
